// ===== rtl/core/matrix_multiply_macros.svh =====
// Assertion helpers for the top-level block, which checks itself.
// All checks sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define MM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mm_pkg.sv =====
package mm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SIZE_W      = 4;
	localparam int IDX_W       = 3;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int ACC_W       = 35;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_ROWS_M  = 2'd0;
	localparam logic [1:0] REG_INNER_N = 2'd1;
	localparam logic [1:0] REG_COLS_K  = 2'd2;

	typedef enum logic [1:0] {
		FUNC_WR_A    = 2'd0,
		FUNC_WR_B    = 2'd1,
		FUNC_COMPUTE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] rows_m;
		logic [SIZE_W-1:0] inner_n;
		logic [SIZE_W-1:0] cols_k;
	} dims_t;

	// Controller to datapath.
	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic start;
		logic issue;
		logic commit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic k_end;
		logic elem_last;
		logic acc_done;
		logic out_busy;
	} sts_t;

	function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_W'(1);
		else if (v > SIZE_W'(MAX_DIM)) r = SIZE_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		logic [2*IDX_W-1:0] t;
		t = (2*IDX_W)'(r) * (2*IDX_W)'(MAX_DIM) + (2*IDX_W)'(c);
		return ADDR_W'(t);
	endfunction

endpackage

// ===== rtl/core/mm_ctrl.sv =====
module mm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_func,
	output logic          in_ready,
	input  mm_pkg::sts_t  sts,
	output mm_pkg::cmd_t  cmd
);
	import mm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					unique case (in_func)
						FUNC_WR_A: cmd.wr_a = 1'b1;
						FUNC_WR_B: cmd.wr_b = 1'b1;
						FUNC_COMPUTE: begin
							cmd.start = 1'b1;
							state_d   = ST_RUN;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.k_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// The finished sum moves out once the output register can take it.
				if (sts.acc_done && !sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = sts.elem_last ? ST_IDLE : ST_RUN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/mm_dp.sv =====
module mm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mm_pkg::dims_t                    dims,
	input  mm_pkg::cmd_t                     cmd,
	output mm_pkg::sts_t                     sts,
	input  logic [mm_pkg::IDX_W-1:0]         wr_row,
	input  logic [mm_pkg::IDX_W-1:0]         wr_col,
	input  logic signed [mm_pkg::ELEM_W-1:0] wr_value,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [mm_pkg::IDX_W-1:0]         out_row,
	output logic [mm_pkg::IDX_W-1:0]         out_col,
	output logic signed [mm_pkg::ACC_W-1:0]  out_value,
	output logic                             out_last
);
	import mm_pkg::*;

	logic [ELEM_W-1:0] a_mem [STORE_DEPTH];
	logic [ELEM_W-1:0] b_mem [STORE_DEPTH];

	logic [DIM_W-1:0] i_q, j_q, k_q;
	logic             k_end, j_end, i_end;
	logic             wr_ok;
	logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

	logic signed [ELEM_W-1:0] a_rd_s1, b_rd_s1;
	logic                     valid_s1, first_s1, end_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2, first_s2, end_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic                     done_q;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_row_q, out_col_q;
	logic signed [ACC_W-1:0]  out_value_q;
	logic                     out_last_q;

	assign k_end = ({1'b0, k_q} == SIZE_W'(dims.inner_n - 1'b1));
	assign j_end = ({1'b0, j_q} == SIZE_W'(dims.cols_k - 1'b1));
	assign i_end = ({1'b0, i_q} == SIZE_W'(dims.rows_m - 1'b1));

	assign wr_ok   = ({1'b0, wr_row} < SIZE_W'(MAX_DIM)) && ({1'b0, wr_col} < SIZE_W'(MAX_DIM));
	assign wr_addr = store_addr(wr_row, wr_col);
	assign a_addr  = store_addr(IDX_W'(i_q), IDX_W'(k_q));
	assign b_addr  = store_addr(IDX_W'(k_q), IDX_W'(j_q));

	always_ff @(posedge clk) begin
		if (cmd.wr_a && wr_ok) a_mem[wr_addr] <= wr_value;
		if (cmd.issue) a_rd_s1 <= a_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b && wr_ok) b_mem[wr_addr] <= wr_value;
		if (cmd.issue) b_rd_s1 <= b_mem[b_addr];
	end

	// Element and dot-product counters; i and j only step forward when a sum leaves, and all three clear on start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (cmd.start) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.issue) k_q <= k_end ? '0 : k_q + 1'b1;
			if (cmd.commit) begin
				if (j_end) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			if (cmd.start || cmd.commit) done_q <= 1'b0;
			else if (valid_s2 && end_s2) done_q <= 1'b1;
		end
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		end_s1   <= k_end;
		prod_s2  <= a_rd_s1 * b_rd_s1;
		first_s2 <= first_s1;
		end_s2   <= end_s1;
		if (valid_s2) acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_row_q   <= IDX_W'(i_q);
			out_col_q   <= IDX_W'(j_q);
			out_value_q <= acc_q;
			out_last_q  <= i_end && j_end;
		end
	end

	assign sts.k_end     = k_end;
	assign sts.elem_last = i_end && j_end;
	assign sts.acc_done  = done_q;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/core/matrix_multiply.sv =====
// Dense matrix multiply C = A * B on signed Q8.8 elements with exact Q19.16 sums.
// Set rows_m, inner_n and cols_k over the register port (0 reads as 1, above 8 reads
// as 8), load A and B one element per input request (tuser 0 for A, 1 for B, at the
// given row and column), then send a request with tuser 2: the block streams the
// rows_m by cols_k product in row-major order, tlast on the final element. Each
// product element runs through the single multiply-accumulate pipeline (store
// read, multiply, accumulate), and the reads for the next element start only once
// the previous sum has moved to the output register. No input is taken during a
// compute run; the final element may still wait in the output register while new
// loads are taken. Elements never written since reset read as unknown.
`include "matrix_multiply_macros.svh"

module matrix_multiply (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // row [2:0], col [5:3], value [21:6], zero [23:22]
	input  logic [1:0]  s_axis_tuser,  // func [1:0]
	// Product elements
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_row [2:0], out_col [5:3], out_value [40:6],
	                                   // zero [47:41]
	output logic        m_axis_tlast
);
	import mm_pkg::*;

	dims_t dims_q;
	cmd_t  cmd;
	sts_t  sts;
	logic  cfg_wr;

	logic [IDX_W-1:0]        out_row, out_col;
	logic signed [ACC_W-1:0] out_value;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.rows_m  <= SIZE_W'(MAX_DIM);
			dims_q.inner_n <= SIZE_W'(MAX_DIM);
			dims_q.cols_k  <= SIZE_W'(MAX_DIM);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROWS_M:  dims_q.rows_m  <= clamp_dim(pwdata[SIZE_W-1:0]);
				REG_INNER_N: dims_q.inner_n <= clamp_dim(pwdata[SIZE_W-1:0]);
				REG_COLS_K:  dims_q.cols_k  <= clamp_dim(pwdata[SIZE_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS_M:  prdata = 32'(dims_q.rows_m);
			REG_INNER_N: prdata = 32'(dims_q.inner_n);
			REG_COLS_K:  prdata = 32'(dims_q.cols_k);
			default:     prdata = '0;
		endcase
	end

	mm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims_q),
		.cmd       (cmd),
		.sts       (sts),
		.wr_row    (s_axis_tdata[2:0]),
		.wr_col    (s_axis_tdata[5:3]),
		.wr_value  (s_axis_tdata[21:6]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'b0, out_value, out_col, out_row};

	// No store reads are issued while the block takes input requests.
	`MM_ASSERT_SAME(a_no_issue_idle, s_axis_tready, !cmd.issue, "read issued while idle")
	// A finished sum never overwrites a result that has not been taken.
	`MM_ASSERT_SAME(a_commit_free, cmd.commit, !sts.out_busy, "output overwritten")
	// Handing out the final element of a run returns the block to idle.
	`MM_ASSERT_NEXT(a_last_idle, cmd.commit && sts.elem_last, s_axis_tready,
		"not idle after final element")

endmodule

// ===== tb/tb_matrix_multiply.sv =====
`timescale 1ns / 1ps

module tb_matrix_multiply;
	import mm_pkg::*;

	localparam int          RAND_REQS = 300;
	localparam int          SETTLE    = 16;
	localparam int          HOLD_OFF  = 600;
	localparam int unsigned LIMIT     = 400000;
	localparam int          DIR_ROWS  = 28;

	// Codes with no name in the package: the unused function and a register past the list.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] REG_NONE    = 2'd3;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [34:0] sum;
		logic        last;
	} elem_t;

	// One line of the directed table: a register write or an input request.
	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  code;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [15:0] value;
		logic        known;
		logic [34:0] sum;
	} step_t;

	localparam step_t DIR_TABLE [DIR_ROWS] = '{
		'{1'b1, REG_ROWS_M,   3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
		'{1'b1, REG_INNER_N,  3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
		'{1'b1, REG_COLS_K,   3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_A,    3'd0, 3'd0, 16'h7FFF, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_B,    3'd0, 3'd0, 16'h7FFF, 1'b0, 35'd0},
		'{1'b0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 35'h0_3FFF_0001},
		'{1'b0, FUNC_WR_B,    3'd0, 3'd0, 16'h8000, 1'b0, 35'd0},
		'{1'b0, FUNC_COMPUTE, 3'd5, 3'd2, 16'hFFFF, 1'b1, 35'h7_C000_8000},
		'{1'b0, FUNC_WR_A,    3'd0, 3'd0, 16'h8000, 1'b0, 35'd0},
		'{1'b0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 35'h0_4000_0000},
		'{1'b0, FUNC_UNUSED,  3'd7, 3'd7, 16'hFFFF, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_A,    3'd7, 3'd7, 16'h1234, 1'b0, 35'd0},
		'{1'b1, REG_NONE,     3'd0, 3'd0, 16'h0005, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_A,    3'd0, 3'd0, 16'h0000, 1'b0, 35'd0},
		'{1'b0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 35'd0},
		'{1'b1, REG_ROWS_M,   3'd0, 3'd0, 16'h0002, 1'b0, 35'd0},
		'{1'b1, REG_INNER_N,  3'd0, 3'd0, 16'h0002, 1'b0, 35'd0},
		'{1'b1, REG_COLS_K,   3'd0, 3'd0, 16'h0002, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_A,    3'd0, 3'd0, 16'h0100, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_A,    3'd0, 3'd1, 16'hFFFF, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_A,    3'd1, 3'd0, 16'h8001, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_A,    3'd1, 3'd1, 16'h7FFF, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_B,    3'd0, 3'd0, 16'h5555, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_B,    3'd0, 3'd1, 16'hAAAA, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_B,    3'd1, 3'd0, 16'h00FF, 1'b0, 35'd0},
		'{1'b0, FUNC_WR_B,    3'd1, 3'd1, 16'hFF00, 1'b0, 35'd0},
		'{1'b0, FUNC_UNUSED,  3'd2, 3'd5, 16'h2AD4, 1'b0, 35'd0},
		'{1'b0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, 35'd0}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [3:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;  // row [2:0], col [5:3], value [21:6], zero [23:22]
	logic [1:0]  s_axis_tuser  = '0;  // func [1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // out_row [2:0], out_col [5:3], out_value [40:6],
	                                  // zero [47:41]
	logic        m_axis_tlast;

	matrix_multiply u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// Shadow copy of the block: both element stores and the three sizes.
	logic [15:0] a_elem [MAX_DIM][MAX_DIM];
	logic [15:0] b_elem [MAX_DIM][MAX_DIM];
	logic [3:0]  dim_m = 4'd8;
	logic [3:0]  dim_n = 4'd8;
	logic [3:0]  dim_k = 4'd8;
	elem_t       product_q [$];

	int          req_count    = 0;
	int          counted_reqs = 0;
	int          run_count    = 0;
	int          elem_count   = 0;
	int          size_writes  = 0;
	int          mismatches   = 0;
	int unsigned cycle_cnt    = 0;
	logic        quiet        = 1'b0;
	logic        hold_arm     = 1'b0;
	logic        hold_done    = 1'b0;
	int          hold_left    = 0;

	function automatic logic [3:0] fit_dim(input logic [3:0] raw);
		if (raw == 4'd0) return 4'd1;
		if (raw > 4'(MAX_DIM)) return 4'(MAX_DIM);
		return raw;
	endfunction

	function automatic logic [3:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) return 4'd0;
		if (roll < 20) return 4'd1;
		if (roll < 30) return 4'($urandom_range(9, 15));
		if (roll < 40) return 4'd8;
		return 4'($urandom_range(1, 8));
	endfunction

	function automatic logic [15:0] pick_value();
		if ($urandom_range(99) >= 12) return 16'($urandom());
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// The register only keeps the low four bits, so the upper ones get random junk now and then.
	function automatic logic [31:0] size_word(input logic [3:0] raw);
		return {($urandom_range(1) != 0) ? 28'($urandom()) : 28'd0, raw};
	endfunction

	task automatic multiply_stores();
		elem_t  e;
		longint acc;
		for (int i = 0; i < int'(dim_m); i++) begin
			for (int j = 0; j < int'(dim_k); j++) begin
				acc = 0;
				for (int k = 0; k < int'(dim_n); k++) begin
					acc += longint'($signed(a_elem[i][k])) * longint'($signed(b_elem[k][j]));
				end
				e.row  = 3'(i);
				e.col  = 3'(j);
				e.sum  = acc[34:0];
				e.last = (i + 1 == int'(dim_m)) && (j + 1 == int'(dim_k));
				product_q.push_back(e);
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic send_request(input logic [1:0] func, input logic [2:0] row,
		input logic [2:0] col, input logic [15:0] value, input logic known,
		input logic [34:0] sum);
		elem_t e;
		if (!quiet && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {2'b00, value, col, row};
		do @(posedge clk); while (!s_axis_tready);
		req_count++;
		if (func != FUNC_UNUSED) counted_reqs++;
		if (func == FUNC_WR_A) begin
			a_elem[row][col] = value;
		end else if (func == FUNC_WR_B) begin
			b_elem[row][col] = value;
		end else if (func == FUNC_COMPUTE) begin
			run_count++;
			if (known) begin
				e = '{3'd0, 3'd0, sum, 1'b1};
				product_q.push_back(e);
			end else begin
				multiply_stores();
			end
		end
	endtask

	// Loads leave no trace on the output, so keep waiting after the last product element is taken.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (product_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_size(input logic [1:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		size_writes++;
		if (idx == REG_ROWS_M) dim_m = fit_dim(data[3:0]);
		else if (idx == REG_INNER_N) dim_n = fit_dim(data[3:0]);
		else if (idx == REG_COLS_K) dim_k = fit_dim(data[3:0]);
	endtask

	task automatic random_request();
		logic [1:0] func;
		logic [2:0] row;
		logic [2:0] col;
		if ($urandom_range(99) < 5) begin
			send_request(FUNC_UNUSED, 3'($urandom()), 3'($urandom()), 16'($urandom()), 1'b0, '0);
		end else begin
			func = ($urandom_range(1) != 0) ? FUNC_WR_B : FUNC_WR_A;
			if ($urandom_range(99) < 85) begin
				// Mostly hit the part of the store that the current sizes read.
				row = 3'($urandom_range(int'(func == FUNC_WR_A ? dim_m : dim_n) - 1));
				col = 3'($urandom_range(int'(func == FUNC_WR_A ? dim_n : dim_k) - 1));
			end else begin
				row = 3'($urandom());
				col = 3'($urandom());
			end
			send_request(func, row, col, pick_value(), 1'b0, '0);
		end
	endtask

	// Receiver: random back-pressure, plus one long hold-off once the sender arms it.
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_done     <= 1'b1;
			hold_left     <= HOLD_OFF;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(99) >= 8);
		end
	end

	always @(posedge clk) begin
		elem_t got;
		elem_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[40:6], m_axis_tlast};
			elem_count++;
			if (product_q.size() == 0) begin
				report_mismatch($sformatf("unexpected element row %0d col %0d value %h",
					got.row, got.col, got.sum));
			end else begin
				want = product_q.pop_front();
				if (got.row != want.row)
					report_mismatch($sformatf("out_row %0d, wanted %0d", got.row, want.row));
				if (got.col != want.col)
					report_mismatch($sformatf("out_col %0d, wanted %0d", got.col, want.col));
				if (got.sum != want.sum)
					report_mismatch($sformatf("out_value %h, wanted %h at (%0d,%0d)",
						got.sum, want.sum, want.row, want.col));
				if (got.last != want.last)
					report_mismatch($sformatf("tlast %0d, wanted %0d at (%0d,%0d)",
						got.last, want.last, want.row, want.col));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("Timed out after %0d cycles with %0d elements outstanding.",
				cycle_cnt, product_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		step_t      step;
		int         phase;
		int         rounds;
		int         dir_end;
		logic [3:0] raw_m;
		logic [3:0] raw_n;
		logic [3:0] raw_k;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int s = 0; s < DIR_ROWS; s++) begin
			step = DIR_TABLE[s];
			if (step.is_cfg) begin
				wait_drained();
				program_size(step.code, 32'(step.value));
			end else begin
				send_request(step.code, step.row, step.col, step.value, step.known, step.sum);
			end
		end
		dir_end = counted_reqs;

		phase = 0;
		while (counted_reqs - dir_end < RAND_REQS) begin
			quiet <= (phase == 2) || (phase == 3);
			wait_drained();
			if (phase == 0) begin
				// Above-range sizes saturate to the full 8 by 8 by 8 case.
				raw_m = 4'd15;
				raw_n = 4'd15;
				raw_k = 4'd15;
			end else if (phase == 1) begin
				raw_m = 4'd8;
				raw_n = 4'd8;
				raw_k = 4'd8;
			end else begin
				raw_m = pick_size();
				raw_n = pick_size();
				raw_k = pick_size();
			end
			program_size(REG_ROWS_M, size_word(raw_m));
			program_size(REG_INNER_N, size_word(raw_n));
			program_size(REG_COLS_K, size_word(raw_k));

			if (phase == 0) begin
				// Fill every entry of both stores with the most negative value. This gives the
				// largest possible sum, and no later product reads an entry never written.
				for (int r = 0; r < MAX_DIM; r++)
					for (int c = 0; c < MAX_DIM; c++)
						send_request(FUNC_WR_A, 3'(r), 3'(c), 16'h8000, 1'b0, '0);
				for (int r = 0; r < MAX_DIM; r++)
					for (int c = 0; c < MAX_DIM; c++)
						send_request(FUNC_WR_B, 3'(r), 3'(c), 16'h8000, 1'b0, '0);
				send_request(FUNC_COMPUTE, 3'($urandom()), 3'($urandom()), 16'($urandom()),
					1'b0, '0);
			end else begin
				rounds = (phase == 1) ? 2 : $urandom_range(1, 2);
				repeat (rounds) begin
					repeat ($urandom_range(4, 20)) random_request();
					send_request(FUNC_COMPUTE, 3'($urandom()), 3'($urandom()),
						16'($urandom()), 1'b0, '0);
					// The output stalls during this full-size run, so the run and the loads behind it wait.
					if (phase == 1 && !hold_arm) hold_arm <= 1'b1;
				end
			end
			phase++;
		end

		s_axis_tvalid <= 1'b0;
		while (product_q.size() != 0) @(posedge clk);
		repeat (4 * SETTLE) @(posedge clk);

		$display("Ran %0d requests with %0d product runs; %0d product elements checked.",
			req_count, run_count, elem_count);
		$display("Programmed sizes %0d times over %0d random phases, 1x1x1 through 8x8x8.",
			size_writes, phase);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches.", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mm_pkg.sv
rtl/core/mm_ctrl.sv
rtl/core/mm_dp.sv
rtl/core/matrix_multiply.sv
tb/tb_matrix_multiply.sv
